/* design/gtg_pkg.sv */
package gtg_pkg;

   // field widths
   localparam int unsigned COORD_W = 12;
   localparam int unsigned GAP_W   = 13;
   localparam int unsigned STEP_W  = 14;
   localparam int unsigned EDGE_W  = 15;
   localparam int unsigned SPAN_W  = 13;
   localparam int unsigned CNT_W   = 5;
   localparam int unsigned POS_W   = 4;
   localparam int unsigned IDX_W   = 6;

   // job queue between front and back
   localparam int unsigned JOBQ_DEPTH = 2;
   localparam int unsigned JOBQ_PTR_W = $clog2(JOBQ_DEPTH);
   localparam int unsigned JOBQ_CNT_W = $clog2(JOBQ_DEPTH + 1);

   // remainder policy codes
   localparam logic [1:0] POL_DISCARD = 2'd0;
   localparam logic [1:0] POL_KEEP    = 2'd1;

   // register indexes
   localparam logic [2:0] REG_ORIGIN_X    = 3'd0;
   localparam logic [2:0] REG_ORIGIN_Y    = 3'd1;
   localparam logic [2:0] REG_CELL_WIDTH  = 3'd2;
   localparam logic [2:0] REG_CELL_HEIGHT = 3'd3;
   localparam logic [2:0] REG_GAP_X       = 3'd4;
   localparam logic [2:0] REG_GAP_Y       = 3'd5;
   localparam logic [2:0] REG_WANTED_GRID = 3'd6;
   localparam logic [2:0] REG_POLICY      = 3'd7;

   typedef struct packed {
      logic [COORD_W-1:0] origin_x;
      logic [COORD_W-1:0] origin_y;
      logic [COORD_W-1:0] cell_width;
      logic [COORD_W-1:0] cell_height;
      logic [GAP_W-1:0]   gap_x;
      logic [GAP_W-1:0]   gap_y;
      logic [7:0]         wanted_grid;
      logic [1:0]         remainder_policy;
   } cfg_type;

   typedef struct packed {
      logic [CNT_W-1:0]   ncols;
      logic [CNT_W-1:0]   nrows;
      logic [COORD_W-1:0] image_width;
      logic [COORD_W-1:0] image_height;
   } job_type;

   typedef struct packed {
      logic [2:0]         cell_row;
      logic [2:0]         cell_col;
      logic [IDX_W-1:0]   cell_index;
      logic [COORD_W-1:0] left_edge;
      logic [COORD_W-1:0] top_edge;
      logic [SPAN_W-1:0]  right_edge;
      logic [SPAN_W-1:0]  bottom_edge;
      logic               partial_cell;
      logic               grid_empty;
      logic               last_cell;
   } result_type;

   typedef enum logic {
      FRONT_IDLE,
      FRONT_COUNT
   } front_state_type;

   typedef enum logic {
      BACK_IDLE,
      BACK_RUN
   } back_state_type;

   // cell size plus signed gap
   function automatic logic [STEP_W-1:0] step_of(input logic [COORD_W-1:0] size,
                                                 input logic [GAP_W-1:0] gap);
      step_of = {2'b00, size} + {gap[GAP_W-1], gap};
   endfunction

   // step usable: strictly positive
   function automatic logic step_ok(input logic [STEP_W-1:0] step);
      step_ok = !step[STEP_W-1] && (step != '0);
   endfunction

endpackage

/* design/gtg_front.sv */
module gtg_front import gtg_pkg::*; #(
   parameter int unsigned MAX_COLS = 8,
   parameter int unsigned MAX_ROWS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               req_push,
   output logic               req_full,
   input  logic [COORD_W-1:0] req_image_width,
   input  logic [COORD_W-1:0] req_image_height,
   input  logic               job_full,
   output logic               job_push,
   output job_type            job_data
);

   localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_COLS);
   localparam logic [CNT_W-1:0] MAX_R = CNT_W'(MAX_ROWS);

   front_state_type    state_ff, state_in;
   logic [COORD_W-1:0] iw_ff, iw_in, ih_ff, ih_in;
   logic [CNT_W-1:0]   nx_ff, nx_in, ny_ff, ny_in;
   logic [EDGE_W-1:0]  ex_ff, ex_in, ey_ff, ey_in;
   logic               dx_ff, dx_in, dy_ff, dy_in;

   logic [STEP_W-1:0]  step_x, step_y;
   logic               grid_ok;
   logic [CNT_W-1:0]   want_c, want_r;
   logic               stop_x, stop_y;
   logic               discard;
   logic               accept;

   // steps and clamped wanted counts
   always_comb begin
      step_x  = step_of(cfg.cell_width, cfg.gap_x);
      step_y  = step_of(cfg.cell_height, cfg.gap_y);
      grid_ok = (cfg.cell_width != '0) && (cfg.cell_height != '0) &&
                step_ok(step_x) && step_ok(step_y);
      want_c  = (cfg.wanted_grid[3:0] == 4'd0 || {1'b0, cfg.wanted_grid[3:0]} > MAX_C)
                ? MAX_C : {1'b0, cfg.wanted_grid[3:0]};
      want_r  = (cfg.wanted_grid[7:4] == 4'd0 || {1'b0, cfg.wanted_grid[7:4]} > MAX_R)
                ? MAX_R : {1'b0, cfg.wanted_grid[7:4]};
      discard = (cfg.remainder_policy == POL_DISCARD);
   end

   // stop tests for the cell at the current edge
   always_comb begin
      stop_x = (nx_ff >= want_c) || (ex_ff >= EDGE_W'(iw_ff)) ||
               (discard && (ex_ff + EDGE_W'(cfg.cell_width)) > EDGE_W'(iw_ff));
      stop_y = (ny_ff >= want_r) || (ey_ff >= EDGE_W'(ih_ff)) ||
               (discard && (ey_ff + EDGE_W'(cfg.cell_height)) > EDGE_W'(ih_ff));
   end

   assign accept = req_push && !req_full;

   // counting pass, one cell per axis each cycle
   always_comb begin
      iw_in = iw_ff;
      ih_in = ih_ff;
      nx_in = nx_ff;
      ny_in = ny_ff;
      ex_in = ex_ff;
      ey_in = ey_ff;
      dx_in = dx_ff;
      dy_in = dy_ff;
      if (accept) begin
         iw_in = req_image_width;
         ih_in = req_image_height;
         nx_in = '0;
         ny_in = '0;
         ex_in = EDGE_W'(cfg.origin_x);
         ey_in = EDGE_W'(cfg.origin_y);
         dx_in = !grid_ok;
         dy_in = !grid_ok;
      end else if (state_ff == FRONT_COUNT) begin
         if (!dx_ff) begin
            if (stop_x) begin
               dx_in = 1'b1;
            end else begin
               nx_in = nx_ff + CNT_W'(1);
               ex_in = ex_ff + EDGE_W'(step_x[SPAN_W-1:0]);
            end
         end
         if (!dy_ff) begin
            if (stop_y) begin
               dy_in = 1'b1;
            end else begin
               ny_in = ny_ff + CNT_W'(1);
               ey_in = ey_ff + EDGE_W'(step_y[SPAN_W-1:0]);
            end
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FRONT_IDLE: begin
            if (req_push) state_in = FRONT_COUNT;
         end
         FRONT_COUNT: begin
            if (dx_ff && dy_ff && !job_full) state_in = FRONT_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_full = 1'b1;
      job_push = 1'b0;
      unique case (state_ff)
         FRONT_IDLE: begin
            req_full = 1'b0;
         end
         FRONT_COUNT: begin
            job_push = dx_ff && dy_ff && !job_full;
         end
      endcase
   end

   assign job_data = '{ncols: nx_ff, nrows: ny_ff, image_width: iw_ff, image_height: ih_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FRONT_IDLE;
         dx_ff    <= 1'b0;
         dy_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         dx_ff    <= dx_in;
         dy_ff    <= dy_in;
      end
      iw_ff <= iw_in;
      ih_ff <= ih_in;
      nx_ff <= nx_in;
      ny_ff <= ny_in;
      ex_ff <= ex_in;
      ey_ff <= ey_in;
   end

endmodule

/* design/gtg_job_queue.sv */
module gtg_job_queue import gtg_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  job_type push_data,
   input  logic    pop,
   output logic    empty,
   output job_type pop_data
);

   job_type                entries_ff [JOBQ_DEPTH];
   logic [JOBQ_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [JOBQ_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [JOBQ_CNT_W-1:0]  count_ff, count_in;
   logic                   do_push, do_pop;

   localparam logic [JOBQ_PTR_W-1:0] LAST_PTR = JOBQ_PTR_W'(JOBQ_DEPTH - 1);
   localparam logic [JOBQ_CNT_W-1:0] FULL_CNT = JOBQ_CNT_W'(JOBQ_DEPTH);

   assign full     = (count_ff == FULL_CNT);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entries_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + JOBQ_PTR_W'(1);
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + JOBQ_PTR_W'(1);
      if (do_push && !do_pop) count_in = count_ff + JOBQ_CNT_W'(1);
      if (do_pop && !do_push) count_in = count_ff - JOBQ_CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) entries_ff[wr_ptr_ff] <= push_data;
   end

endmodule

/* design/gtg_back.sv */
module gtg_back import gtg_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       job_empty,
   input  job_type    job_data,
   output logic       job_pop,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output result_type rsp_word
);

   localparam logic [IDX_W-1:0] LAST_IDX = '1;

   back_state_type     state_ff, state_in;
   job_type            job_ff, job_in;
   logic [POS_W-1:0]   r_ff, r_in, c_ff, c_in;
   logic [IDX_W-1:0]   k_ff, k_in;
   logic [COORD_W-1:0] left_ff, left_in, top_ff, top_in;
   logic               out_valid_ff, out_valid_in;
   result_type         out_ff, out_in;

   logic               slot_free, emit, empty_job;
   logic               last_col, last_row, last;
   logic [STEP_W-1:0]  step_x, step_y;
   logic [SPAN_W-1:0]  right, bottom;
   logic               part_x, part_y, keep;
   result_type         cell_word;

   assign slot_free = !out_valid_ff || rsp_pop;
   assign step_x    = step_of(cfg.cell_width, cfg.gap_x);
   assign step_y    = step_of(cfg.cell_height, cfg.gap_y);
   assign keep      = (cfg.remainder_policy == POL_KEEP);

   // position tests
   always_comb begin
      empty_job = (job_ff.ncols == '0) || (job_ff.nrows == '0);
      last_col  = ({1'b0, c_ff} + CNT_W'(1)) == job_ff.ncols;
      last_row  = ({1'b0, r_ff} + CNT_W'(1)) == job_ff.nrows;
      last      = empty_job || (k_ff == LAST_IDX) || (last_row && last_col);
   end

   // cell rectangle and flags
   always_comb begin
      right  = {1'b0, left_ff} + {1'b0, cfg.cell_width};
      bottom = {1'b0, top_ff} + {1'b0, cfg.cell_height};
      part_x = right > {1'b0, job_ff.image_width};
      part_y = bottom > {1'b0, job_ff.image_height};
      if (empty_job) begin
         cell_word            = '0;
         cell_word.grid_empty = 1'b1;
         cell_word.last_cell  = 1'b1;
      end else begin
         cell_word.cell_row     = r_ff[2:0];
         cell_word.cell_col     = c_ff[2:0];
         cell_word.cell_index   = k_ff;
         cell_word.left_edge    = left_ff;
         cell_word.top_edge     = top_ff;
         cell_word.right_edge   = (part_x && keep) ? {1'b0, job_ff.image_width} : right;
         cell_word.bottom_edge  = (part_y && keep) ? {1'b0, job_ff.image_height} : bottom;
         cell_word.partial_cell = part_x || part_y;
         cell_word.grid_empty   = 1'b0;
         cell_word.last_cell    = last;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BACK_IDLE: begin
            if (!job_empty) state_in = BACK_RUN;
         end
         BACK_RUN: begin
            if (slot_free && last) state_in = BACK_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      job_pop = 1'b0;
      emit    = 1'b0;
      unique case (state_ff)
         BACK_IDLE: begin
            job_pop = !job_empty;
         end
         BACK_RUN: begin
            emit = slot_free;
         end
      endcase
   end

   // walk the grid in row-major order
   always_comb begin
      job_in  = job_ff;
      r_in    = r_ff;
      c_in    = c_ff;
      k_in    = k_ff;
      left_in = left_ff;
      top_in  = top_ff;
      if (job_pop) begin
         job_in  = job_data;
         r_in    = '0;
         c_in    = '0;
         k_in    = '0;
         left_in = cfg.origin_x;
         top_in  = cfg.origin_y;
      end else if (emit && !last) begin
         k_in = k_ff + IDX_W'(1);
         if (last_col) begin
            c_in    = '0;
            r_in    = r_ff + POS_W'(1);
            left_in = cfg.origin_x;
            top_in  = top_ff + step_y[COORD_W-1:0];
         end else begin
            c_in    = c_ff + POS_W'(1);
            left_in = left_ff + step_x[COORD_W-1:0];
         end
      end
   end

   // output word register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_in       = cell_word;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_word  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      job_ff  <= job_in;
      r_ff    <= r_in;
      c_ff    <= c_in;
      k_ff    <= k_in;
      left_ff <= left_in;
      top_ff  <= top_in;
      out_ff  <= out_in;
   end

endmodule

/* design/grid_tile_generator_unit.sv */
// channel  | direction | handshake                  | fields
// ---------+-----------+----------------------------+---------------------------------------
// req      | in        | push / full                | image_width, image_height
// rsp      | out       | empty / pop                | cell_row .. last_cell, one word a cell
// csr      | in        | apb psel/penable, pready=1 | eight registers at byte address 4*i
//
// a counting pass in the front part steps one column and one row per cycle;
// the back part pops a job, then gives one word per cycle while the output word is free or
// popped, ncols * nrows words (at most 64), or one word for an empty grid.
// the two-entry job queue between them lets the front part count the next image early.
// reset clears control state and loads the register reset values; rsp_pop held low stalls
// the back part, then the job queue fills, then req_full stays high.
module grid_tile_generator_unit import gtg_pkg::*; #(
   parameter int unsigned MAX_COLS = 8,
   parameter int unsigned MAX_ROWS = 8
) (
   input  logic               clock,
   input  logic               reset,
   // configuration
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [4:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready,
   // input words
   input  logic               req_push,
   output logic               req_full,
   input  logic [COORD_W-1:0] req_image_width,
   input  logic [COORD_W-1:0] req_image_height,
   // result words
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [2:0]         rsp_cell_row,
   output logic [2:0]         rsp_cell_col,
   output logic [IDX_W-1:0]   rsp_cell_index,
   output logic [COORD_W-1:0] rsp_left_edge,
   output logic [COORD_W-1:0] rsp_top_edge,
   output logic [SPAN_W-1:0]  rsp_right_edge,
   output logic [SPAN_W-1:0]  rsp_bottom_edge,
   output logic               rsp_partial_cell,
   output logic               rsp_grid_empty,
   output logic               rsp_last_cell
);

   cfg_type    cfg_ff, cfg_in;
   logic       csr_write;
   logic       job_push, job_full, job_pop, job_empty;
   job_type    job_wr, job_rd;
   result_type rsp_word;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_paddr[4:2])
            REG_ORIGIN_X:    cfg_in.origin_x         = csr_pwdata[COORD_W-1:0];
            REG_ORIGIN_Y:    cfg_in.origin_y         = csr_pwdata[COORD_W-1:0];
            REG_CELL_WIDTH:  cfg_in.cell_width       = csr_pwdata[COORD_W-1:0];
            REG_CELL_HEIGHT: cfg_in.cell_height      = csr_pwdata[COORD_W-1:0];
            REG_GAP_X:       cfg_in.gap_x            = csr_pwdata[GAP_W-1:0];
            REG_GAP_Y:       cfg_in.gap_y            = csr_pwdata[GAP_W-1:0];
            REG_WANTED_GRID: cfg_in.wanted_grid      = csr_pwdata[7:0];
            REG_POLICY:      cfg_in.remainder_policy = csr_pwdata[1:0];
         endcase
      end
   end

   // register reads
   always_comb begin
      unique case (csr_paddr[4:2])
         REG_ORIGIN_X:    csr_prdata = 32'(cfg_ff.origin_x);
         REG_ORIGIN_Y:    csr_prdata = 32'(cfg_ff.origin_y);
         REG_CELL_WIDTH:  csr_prdata = 32'(cfg_ff.cell_width);
         REG_CELL_HEIGHT: csr_prdata = 32'(cfg_ff.cell_height);
         REG_GAP_X:       csr_prdata = 32'(cfg_ff.gap_x);
         REG_GAP_Y:       csr_prdata = 32'(cfg_ff.gap_y);
         REG_WANTED_GRID: csr_prdata = 32'(cfg_ff.wanted_grid);
         REG_POLICY:      csr_prdata = 32'(cfg_ff.remainder_policy);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{origin_x: '0, origin_y: '0,
                     cell_width: COORD_W'(64), cell_height: COORD_W'(64),
                     gap_x: '0, gap_y: '0, wanted_grid: '0, remainder_policy: POL_DISCARD};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: counts columns and rows
   gtg_front #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_image_width  (req_image_width),
      .req_image_height (req_image_height),
      .job_full         (job_full),
      .job_push         (job_push),
      .job_data         (job_wr)
   );

   // counted jobs waiting for the back part
   gtg_job_queue u_job_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .full      (job_full),
      .push_data (job_wr),
      .pop       (job_pop),
      .empty     (job_empty),
      .pop_data  (job_rd)
   );

   // back: emits cells
   gtg_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .job_empty (job_empty),
      .job_data  (job_rd),
      .job_pop   (job_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_word  (rsp_word)
   );

   assign rsp_cell_row     = rsp_word.cell_row;
   assign rsp_cell_col     = rsp_word.cell_col;
   assign rsp_cell_index   = rsp_word.cell_index;
   assign rsp_left_edge    = rsp_word.left_edge;
   assign rsp_top_edge     = rsp_word.top_edge;
   assign rsp_right_edge   = rsp_word.right_edge;
   assign rsp_bottom_edge  = rsp_word.bottom_edge;
   assign rsp_partial_cell = rsp_word.partial_cell;
   assign rsp_grid_empty   = rsp_word.grid_empty;
   assign rsp_last_cell    = rsp_word.last_cell;

endmodule
